FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MM4_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MM4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define MM4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mm4_pkg.sv
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int IDX_W     = 2;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W     = TERM_W + IDX_W;
  localparam int CNT_W     = 5;
  localparam int COLS_W    = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;

  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(DIM);

  typedef struct packed {
    logic signed [WORD_W-1:0] element_value;
    logic                     first_of_problem;
  } mm4_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] product_value;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         column_index;
    logic                     last_of_result;
  } mm4_out_t;

  // Store write request from the loader.
  typedef struct packed {
    logic                     we;
    logic                     sel_b;
    logic [ADDR_W-1:0]        addr;
    logic signed [WORD_W-1:0] data;
  } mm4_wr_t;

  // One queued product job: number of B columns minus one.
  typedef struct packed {
    logic [IDX_W-1:0] cols_m1;
  } mm4_job_t;

  // Tag travelling with each multiply-accumulate step.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             final_entry;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm4_tag_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } mm4_state_t;

  function automatic logic signed [WORD_W-1:0] mm4_saturate(
    input logic signed [ACC_W-1:0] acc
  );
    logic [ACC_W-WORD_W:0]    top;
    logic signed [WORD_W-1:0] res;
    top = acc[ACC_W-1:WORD_W-1];
    if ((&top) || !(|top)) begin
      res = acc[WORD_W-1:0];
    end else if (acc[ACC_W-1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

FILE: rtl/mm4_front.sv
module mm4_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  mm4_pkg::mm4_in_t                  in_req,
  input  logic                              cfg_we,
  input  logic [mm4_pkg::COLS_W-1:0]        cfg_wdata,
  output mm4_pkg::mm4_wr_t                  wr,
  output logic                              push,
  output mm4_pkg::mm4_job_t                 push_job
);
  import mm4_pkg::*;

  logic [COLS_W-1:0] columns_r, columns_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              accept;
  logic [IDX_W-1:0]  cols_m1;
  logic [COLS_W-1:0] cols;
  logic [CNT_W:0]    total;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W:0]    pos_next;
  logic              done;
  logic [ADDR_W-1:0] b_idx;
  logic [ADDR_W-1:0] b_row;
  logic [IDX_W-1:0]  b_col;
  logic [7:0]        third;

  assign accept = start && !busy;

  // Out-of-range register values are clamped to one and to DIM columns.
  always_comb begin
    case (columns_r) inside
      3'd0, 3'd1: cols_m1 = 2'd0;
      3'd2:       cols_m1 = 2'd1;
      3'd3:       cols_m1 = 2'd2;
      default:    cols_m1 = 2'd3;
    endcase
  end

  assign cols     = COLS_W'(cols_m1) + 1'b1;
  assign total    = (CNT_W+1)'(DIM * DIM) + ((CNT_W+1)'(cols) << IDX_W);
  assign pos      = in_req.first_of_problem ? '0 : count_r;
  assign pos_next = (CNT_W+1)'(pos) + 1'b1;
  assign done     = pos_next >= total;

  // Position within B split into row and column; a third is taken as
  // a multiplication by eleven and a shift, exact for indices below 16.
  assign b_idx = pos[ADDR_W-1:0];
  assign third = 8'(b_idx) * 8'd11;

  always_comb begin
    case (cols_m1)
      2'd0: begin
        b_row = b_idx;
        b_col = '0;
      end
      2'd1: begin
        b_row = b_idx >> 1;
        b_col = IDX_W'(b_idx[0]);
      end
      2'd2: begin
        b_row = ADDR_W'(third >> 5);
        b_col = IDX_W'(b_idx - (b_row + (b_row << 1)));
      end
      default: begin
        b_row = b_idx >> IDX_W;
        b_col = b_idx[IDX_W-1:0];
      end
    endcase
  end

  always_comb begin
    wr.sel_b = pos[CNT_W-1];
    wr.we    = accept && (!pos[CNT_W-1] || (b_row < ADDR_W'(DIM)));
    wr.addr  = pos[CNT_W-1] ? {b_row[IDX_W-1:0], b_col} : pos[ADDR_W-1:0];
    wr.data  = in_req.element_value;
  end

  assign push             = accept && done;
  assign push_job.cols_m1 = cols_m1;

  always_comb begin
    columns_nxt = cfg_we ? cfg_wdata : columns_r;
    count_nxt   = count_r;
    if (accept) begin
      count_nxt = done ? '0 : pos_next[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLS_RESET;
      count_r   <= '0;
    end else begin
      columns_r <= columns_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

FILE: rtl/mm4_job_queue.sv
module mm4_job_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mm4_pkg::mm4_job_t  push_job,
  input  logic               pop,
  output mm4_pkg::mm4_job_t  pop_job,
  output logic               empty
);
  import mm4_pkg::*;

  mm4_job_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign empty   = (cnt_r == '0);
  assign pop_job = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/mm4_back.sv
module mm4_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mm4_pkg::mm4_wr_t   wr,
  input  logic               q_empty,
  input  mm4_pkg::mm4_job_t  q_job,
  output logic               q_pop,
  output logic               active,
  output logic               out_valid,
  output mm4_pkg::mm4_out_t  out_res
);
  import mm4_pkg::*;

  logic signed [WORD_W-1:0] a_mem [DIM*DIM];
  logic signed [WORD_W-1:0] b_mem [DIM*DIM];

  mm4_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] cols_m1_r, cols_m1_nxt;
  mm4_tag_t         iss;

  logic signed [WORD_W-1:0] a_q_r, b_q_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  sum_r;
  mm4_tag_t                 s1_r, s2_r, s3_r;
  logic                     out_valid_r;
  mm4_out_t                 out_res_r;

  // Sequencer: walks row, column and inner index, one product a cycle.
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    k_nxt       = k_r;
    cols_m1_nxt = cols_m1_r;
    q_pop       = 1'b0;
    iss.valid       = 1'b0;
    iss.first       = (k_r == '0);
    iss.last        = (k_r == IDX_W'(DIM - 1));
    iss.final_entry = (row_r == IDX_W'(DIM - 1)) && (col_r == cols_m1_r);
    iss.row         = row_r;
    iss.col         = col_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cols_m1_nxt = q_job.cols_m1;
          row_nxt     = '0;
          col_nxt     = '0;
          k_nxt       = '0;
          state_nxt   = BK_RUN;
        end
      end
      BK_RUN: begin
        iss.valid = 1'b1;
        k_nxt     = k_r + 1'b1;
        if (k_r == IDX_W'(DIM - 1)) begin
          if (col_r == cols_m1_r) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
            if (row_r == IDX_W'(DIM - 1)) begin
              state_nxt = BK_IDLE;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign prod_nxt = a_q_r * b_q_r;
  // Arithmetic shift right of the product, i.e. rounding towards minus infinity.
  assign term     = $signed(prod_r[PROD_W-1:FRAC_BITS]);
  assign acc_nxt  = (s2_r.first ? '0 : acc_r) + ACC_W'(term);

  // Only the control bits are reset; the data path settles on the first valid step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      s3_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_r.valid  <= iss.valid;
      s2_r.valid  <= s1_r.valid;
      s3_r.valid  <= s2_r.valid && s2_r.last;
      out_valid_r <= s3_r.valid;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      k_r       <= k_nxt;
      cols_m1_r <= cols_m1_nxt;
      s1_r.first       <= iss.first;
      s1_r.last        <= iss.last;
      s1_r.final_entry <= iss.final_entry;
      s1_r.row         <= iss.row;
      s1_r.col         <= iss.col;
      s2_r.first       <= s1_r.first;
      s2_r.last        <= s1_r.last;
      s2_r.final_entry <= s1_r.final_entry;
      s2_r.row         <= s1_r.row;
      s2_r.col         <= s1_r.col;
      s3_r.first       <= s2_r.first;
      s3_r.last        <= s2_r.last;
      s3_r.final_entry <= s2_r.final_entry;
      s3_r.row         <= s2_r.row;
      s3_r.col         <= s2_r.col;
      prod_r <= prod_nxt;
      if (s2_r.valid) begin
        acc_r <= acc_nxt;
      end
      sum_r <= acc_nxt;
      out_res_r.product_value  <= mm4_saturate(sum_r);
      out_res_r.row_index      <= s3_r.row;
      out_res_r.column_index   <= s3_r.col;
      out_res_r.last_of_result <= s3_r.final_entry;
    end
  end

  // Matrix stores: one write port from the loader, one read port each.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      if (wr.sel_b) begin
        b_mem[wr.addr] <= wr.data;
      end else begin
        a_mem[wr.addr] <= wr.data;
      end
    end
    a_q_r <= a_mem[{row_r, k_r}];
    b_q_r <= b_mem[{k_r, col_r}];
  end

  assign active    = (state_r == BK_RUN) || s1_r.valid || s2_r.valid || s3_r.valid
                     || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: rtl/matrix_multiply_4x4.sv
// Loading accepts requests while busy is low: 16 A entries, then 4 rows of B.
// After the final B entry the job is queued and the results come out one by one,
// row by row, from the single shared multiply-accumulate unit; busy stays high
// until the last result is out. The receiver cannot stall.
// Synchronous active-low reset clears the load count and the pipeline and sets
// the column register to four; the matrix stores are not cleared.
`include "assert_macros.svh"

module matrix_multiply_4x4 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  mm4_pkg::mm4_in_t            in_req,
  input  logic                        cfg_we,
  input  logic [mm4_pkg::COLS_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  output mm4_pkg::mm4_out_t           out_res
);
  import mm4_pkg::*;

  mm4_wr_t  wr;
  logic     q_push;
  mm4_job_t q_push_job;
  logic     q_pop;
  mm4_job_t q_pop_job;
  logic     q_empty;
  logic     back_active;

  mm4_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr        (wr),
    .push      (q_push),
    .push_job  (q_push_job)
  );

  mm4_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  mm4_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .q_empty   (q_empty),
    .q_job     (q_pop_job),
    .q_pop     (q_pop),
    .active    (back_active),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // The stores are shared, so no load may start until the last result is out.
  assign busy = !q_empty || back_active;

  `MM4_ASSERT_SAME(a_push_into_empty, q_push, q_empty, "job pushed while one is pending")
  `MM4_ASSERT_SAME(a_out_while_busy, out_valid, busy, "result emitted while not busy")
  `MM4_ASSERT_NEXT(a_last_ends_burst, out_valid && out_res.last_of_result, !out_valid, "result after last")
  `MM4_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty, "pop from empty queue")

endmodule

FILE: tb/matrix_multiply_4x4_test.sv
module matrix_multiply_4x4_test;
  import mm4_pkg::*;

  localparam int     QUIET_CYCLES   = 12;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     RANDOM_ITEMS   = 24;
  localparam longint WORD_MAX       = 64'sd2147483647;
  localparam longint WORD_MIN       = -64'sd2147483648;

  typedef enum logic [2:0] {
    FILL_ZERO,
    FILL_MAX,
    FILL_MIN,
    FILL_LSB,
    FILL_NEG_LSB,
    FILL_IDENT,
    FILL_RAND
  } fill_t;

  typedef struct packed {
    logic [COLS_W-1:0] cols;
    int                junk;
    int                split_at;
    logic [COLS_W-1:0] split_cols;
    fill_t             a_fill;
    fill_t             b_fill;
    logic              has_fixed;
    logic [WORD_W-1:0] fixed_value;
  } case_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  mm4_in_t           in_req    = '0;
  logic              cfg_we    = 1'b0;
  logic [COLS_W-1:0] cfg_wdata = '0;
  logic              out_valid;
  mm4_out_t          out_res;

  matrix_multiply_4x4 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Own copy of the block's state.
  logic signed [WORD_W-1:0] a_words [DIM*DIM];
  logic signed [WORD_W-1:0] b_words [DIM*DIM];
  int unsigned              loaded_count = 0;
  logic [COLS_W-1:0]        cols_setting = COLS_RESET;

  mm4_out_t          expected_products [$];
  int                problems_done = 0;
  int                mismatches    = 0;
  int                idle_cycles   = 0;
  int                items_sent    = 0;
  int                burst_left    = 0;
  logic              fixed_on      = 1'b0;
  logic [WORD_W-1:0] fixed_word    = '0;
  case_t             directed_cases [11];

  initial begin
    foreach (a_words[n]) begin
      a_words[n] = '0;
      b_words[n] = '0;
    end
  end

  function automatic int clamp_cols(logic [COLS_W-1:0] v);
    if (v < 1) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  // Stores one request and, once the load is complete, queues the product.
  task automatic load_entry(mm4_in_t req);
    int       cols;
    int       total;
    int       pos;
    int       idx;
    longint   acc;
    longint   term;
    mm4_out_t res;
    cols  = clamp_cols(cols_setting);
    total = DIM * DIM + DIM * cols;
    if (req.first_of_problem) loaded_count = 0;
    pos = loaded_count;
    if (pos < DIM * DIM) begin
      a_words[pos] = req.element_value;
    end else begin
      idx = pos - DIM * DIM;
      // A position past the last B row is dropped after the register was lowered.
      if (idx / cols < DIM) b_words[(idx / cols) * DIM + idx % cols] = req.element_value;
    end
    loaded_count = pos + 1;
    if (loaded_count < total) return;
    loaded_count = 0;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < cols; c++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++) begin
          term = (longint'(a_words[r*DIM+k]) * longint'(b_words[k*DIM+c])) >>> FRAC_BITS;
          acc += term;
        end
        if (acc > WORD_MAX) acc = WORD_MAX;
        else if (acc < WORD_MIN) acc = WORD_MIN;
        res.product_value  = acc[WORD_W-1:0];
        res.row_index      = IDX_W'(r);
        res.column_index   = IDX_W'(c);
        res.last_of_result = (r == DIM - 1) && (c == cols - 1);
        if (fixed_on) res.product_value = fixed_word;
        expected_products.push_back(res);
      end
    end
    problems_done++;
  endtask

  task automatic note_mismatch(string what, mm4_out_t exp, mm4_out_t got);
    if (mismatches < 10) begin
      $display("%s: expected value %h row %0d col %0d last %b, got value %h row %0d col %0d last %b",
               what, exp.product_value, exp.row_index, exp.column_index, exp.last_of_result,
               got.product_value, got.row_index, got.column_index, got.last_of_result);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    mm4_out_t exp;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_products.size() == 0) begin
          note_mismatch("unexpected result", '0, out_res);
        end else begin
          exp = expected_products.pop_front();
          if (out_res.product_value !== exp.product_value ||
              out_res.row_index !== exp.row_index ||
              out_res.column_index !== exp.column_index ||
              out_res.last_of_result !== exp.last_of_result) begin
            note_mismatch("wrong result", exp, out_res);
          end
        end
      end
      if (cfg_we) cols_setting = cfg_wdata;
      if (start && !busy) load_entry(in_req);
    end
    if (out_valid || cfg_we || (start && !busy)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("matrix_multiply_4x4: mismatch");
        $finish;
      end
    end
  end

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 3))
      0: return WORD_W'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0001_0000;
          3: return -32'sh0001_0000;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] fill_word(fill_t f, int row, int col);
    case (f)
      FILL_ZERO:    return '0;
      FILL_MAX:     return 32'sh7FFF_FFFF;
      FILL_MIN:     return 32'sh8000_0000;
      FILL_LSB:     return 32'sh0000_0001;
      FILL_NEG_LSB: return -32'sh0000_0001;
      FILL_IDENT:   return (row == col) ? 32'sh0001_0000 : 32'sh0;
      default:      return random_word();
    endcase
  endfunction

  // Drives one request at a falling edge and returns at the falling edge after it is taken.
  task automatic send_item(logic signed [WORD_W-1:0] value, logic first);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(5, 20) : $urandom_range(1, 4))
        @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    start                  <= 1'b1;
    in_req.element_value    <= value;
    in_req.first_of_problem <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_cols(logic [COLS_W-1:0] v);
    start <= 1'b0;
    burst_left = 0;
    while (expected_products.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) send_item(random_word(), (i == 0) ? 1'($urandom) : 1'b0);
  endtask

  // Loads requests until the model queues the predicted product, rewriting the register
  // part-way through when split_at is reached.
  task automatic run_problem(fill_t af, fill_t bf, int split_at, logic [COLS_W-1:0] split_cols,
                             logic first0);
    int                       target;
    int                       i;
    int                       cols;
    int                       idx;
    logic signed [WORD_W-1:0] value;
    target = problems_done;
    i      = 0;
    while (problems_done == target) begin
      if (i == split_at) write_cols(split_cols);
      if (i < DIM * DIM) begin
        value = fill_word(af, i / DIM, i % DIM);
      end else begin
        cols  = clamp_cols(cols_setting);
        idx   = i - DIM * DIM;
        value = fill_word(bf, idx / cols, idx % cols);
      end
      send_item(value, (i == 0) ? first0 : 1'b0);
      i++;
    end
  endtask

  initial begin
    int directed_items;
    int kind;
    directed_cases = '{
      '{3'd4, 0, -1, 3'd0, FILL_IDENT,   FILL_RAND,  1'b0, 32'h0000_0000},
      '{3'd1, 0, -1, 3'd0, FILL_MAX,     FILL_MAX,   1'b1, 32'h7FFF_FFFF},
      '{3'd2, 0, -1, 3'd0, FILL_MAX,     FILL_MIN,   1'b1, 32'h8000_0000},
      '{3'd3, 0, -1, 3'd0, FILL_MIN,     FILL_MIN,   1'b1, 32'h7FFF_FFFF},
      '{3'd4, 0, -1, 3'd0, FILL_NEG_LSB, FILL_LSB,   1'b1, 32'hFFFF_FFFC},
      '{3'd0, 0, -1, 3'd0, FILL_LSB,     FILL_LSB,   1'b1, 32'h0000_0000},
      '{3'd5, 0, -1, 3'd0, FILL_ZERO,    FILL_RAND,  1'b1, 32'h0000_0000},
      '{3'd7, 7, -1, 3'd0, FILL_RAND,    FILL_RAND,  1'b0, 32'h0000_0000},
      '{3'd4, 0, 20, 3'd2, FILL_RAND,    FILL_RAND,  1'b0, 32'h0000_0000},
      '{3'd4, 0, 26, 3'd1, FILL_RAND,    FILL_RAND,  1'b0, 32'h0000_0000},
      '{3'd2, 0, 18, 3'd4, FILL_RAND,    FILL_IDENT, 1'b0, 32'h0000_0000}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first case fills every B entry, so later register changes never
    // expose an unwritten store entry.
    foreach (directed_cases[n]) begin
      write_cols(directed_cases[n].cols);
      send_noise(directed_cases[n].junk);
      fixed_on   = directed_cases[n].has_fixed;
      fixed_word = directed_cases[n].fixed_value;
      run_problem(directed_cases[n].a_fill, directed_cases[n].b_fill,
                  directed_cases[n].split_at, directed_cases[n].split_cols, 1'b1);
      fixed_on = 1'b0;
    end
    directed_items = items_sent;

    while (items_sent - directed_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_cols(COLS_W'($urandom_range(0, 7)));
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // A broken request sequence, abandoned by a restart.
        send_noise($urandom_range(1, 12));
        run_problem(FILL_RAND, FILL_RAND, -1, '0, 1'b1);
      end else if (kind == 1) begin
        run_problem(FILL_RAND, FILL_RAND, $urandom_range(16, 30),
                    COLS_W'($urandom_range(0, 7)), 1'($urandom));
      end else begin
        run_problem(FILL_RAND, FILL_RAND, -1, '0, ($urandom_range(0, 3) != 0));
      end
    end

    start <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (4 * QUIET_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("matrix_multiply_4x4: match");
    end else begin
      $display("matrix_multiply_4x4: mismatch");
    end
    $finish;
  end

endmodule
